FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the heatmap colouriser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/lshc_pkg.sv
// Constants, types and the log2 table of the log-scale heatmap colouriser.
package lshc_pkg;

  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES);
  localparam int FRAC_BITS         = 23;
  localparam int POS_W             = FRAC_BITS + $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int TAB_W             = 17;
  localparam int PROD_W            = TAB_W + FRAC_BITS;

  localparam int GAIN_W = 24;
  localparam int VAL_W  = GAIN_W + 1;
  localparam int EXP_W  = 5;
  localparam int LOG_W  = 21;
  localparam int Q_W    = 16;
  localparam int T_W    = Q_W + 1;
  localparam int COL_W  = 8;
  localparam int PIX_W  = T_W + COL_W;

  localparam int NLANES   = 3;
  localparam int LANE_G   = 0;
  localparam int LANE_MIN = 1;
  localparam int LANE_MAX = 2;

  localparam int DIV_STAGES = Q_W;
  localparam int ST_DIV0    = 8;
  localparam int STAGES     = ST_DIV0 + DIV_STAGES + 2;
  localparam int ST_LAST    = STAGES - 1;

  localparam logic [GAIN_W-1:0] MIN_FLOOR       = 24'd7;
  localparam logic [GAIN_W-1:0] SPAN_GAP        = 24'd7;
  localparam logic [LOG_W-1:0]  LOG_SPAN_FLOOR  = 21'd10;
  localparam logic [GAIN_W-1:0] DISPLAY_MIN_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] DISPLAY_MAX_RST = 24'd262144;
  localparam logic [T_W-1:0]    T_ONE           = 17'd65536;
  localparam logic [PIX_W-1:0]  RB_SCALE        = 25'd255;
  localparam logic [PIX_W-1:0]  G_SCALE         = 25'd200;
  localparam logic [COL_W-1:0]  G_PEAK          = 8'd200;

  typedef enum logic [0:0] {
    CFG_DISPLAY_MIN = 1'b0,
    CFG_DISPLAY_MAX = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic line_end;
    logic frame_end;
  } mark_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             row_done;
    logic             frame_done;
  } pix_t;

  typedef logic [TAB_W-1:0] log_tab_t [0:LOG_TABLE_ENTRIES];

  // Entry i holds log2(1 + i/N) in Q0.16, found by bit-serial squaring.
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] x;
    logic [16:0] r;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
      r = '0;
      for (int k = 0; k < 17; k++) begin
        x = (x * x) >> 30;
        r = {r[15:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          x    = x >> 1;
        end
      end
      tab[i] = TAB_W'((18'(r) + 18'd1) >> 1);
    end
    tab[LOG_TABLE_ENTRIES] = T_ONE;
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: rtl/log_scale_heatmap_colorizer.sv
// Log-scale heatmap colouriser: gain pixel stream in, false-colour pixel stream out.
//
// Usage: one unsigned Q8.16 gain per beat enters on the in_ channel (valid/ready) with its
// row and frame end marks, and one red/green/blue beat leaves on the out_ channel with the
// marks copied. The colour runs from blue to red on a logarithmic scale between the two
// display bounds written on the cfg_ port (index 0 lower bound, index 1 upper bound),
// which may only be written while no beat is in flight.
// Throughput: one beat per cycle while the skid register is empty. The depth is set by
// three log2 units (normalise, table index, table read, interpolating multiply, sum)
// followed by a restoring divider that resolves one quotient bit per stage over 16
// stages, then the colour mapping.
// Stalls: the output register is backed by a one-beat skid register, so in_ready is a
// register output and does not depend on out_ready combinationally. While the skid
// register is full the whole pipeline holds; nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) empties the pipeline and both output registers and
// sets the bounds to 1.0 and 4.0.
`include "assert_macros.svh"

module log_scale_heatmap_colorizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_gain_value,
  input  logic        in_line_end,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_row_done,
  output logic        out_frame_done,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int NL = lshc_pkg::NLANES;

  logic [lshc_pkg::GAIN_W-1:0] cfg_min_r, cfg_max_r;

  logic                        en;
  logic [lshc_pkg::STAGES-1:0] vld_r;
  lshc_pkg::mark_t             mark_r [lshc_pkg::STAGES];

  logic [lshc_pkg::GAIN_W-1:0] bnd_min_r, bnd_min_nxt;
  logic [lshc_pkg::VAL_W-1:0]  bnd_max_r, bnd_max_nxt;
  logic [lshc_pkg::GAIN_W-1:0] raw_gain_r;

  logic [lshc_pkg::VAL_W-1:0]     val_r [NL];
  logic [lshc_pkg::VAL_W-1:0]     val_nxt [NL];
  logic [lshc_pkg::EXP_W-1:0]     exp2_r [NL];
  logic [lshc_pkg::EXP_W-1:0]     exp2_nxt [NL];
  logic [lshc_pkg::FRAC_BITS-1:0] frac_r [NL];
  logic [lshc_pkg::FRAC_BITS-1:0] frac_nxt [NL];
  logic [lshc_pkg::EXP_W-1:0]     exp3_r [NL];
  logic [lshc_pkg::IDX_W-1:0]     idx_r [NL];
  logic [lshc_pkg::IDX_W-1:0]     idx_nxt [NL];
  logic [lshc_pkg::FRAC_BITS-1:0] rem3_r [NL];
  logic [lshc_pkg::FRAC_BITS-1:0] rem3_nxt [NL];
  logic [lshc_pkg::EXP_W-1:0]     exp4_r [NL];
  logic [lshc_pkg::TAB_W-1:0]     lo4_r [NL];
  logic [lshc_pkg::TAB_W-1:0]     lo4_nxt [NL];
  logic [lshc_pkg::TAB_W-1:0]     dlt_r [NL];
  logic [lshc_pkg::TAB_W-1:0]     dlt_nxt [NL];
  logic [lshc_pkg::FRAC_BITS-1:0] rem4_r [NL];
  logic [lshc_pkg::EXP_W-1:0]     exp5_r [NL];
  logic [lshc_pkg::TAB_W-1:0]     lo5_r [NL];
  logic [lshc_pkg::PROD_W-1:0]    prod_r [NL];
  logic [lshc_pkg::PROD_W-1:0]    prod_nxt [NL];
  logic [lshc_pkg::LOG_W-1:0]     log_r [NL];
  logic [lshc_pkg::LOG_W-1:0]     log_nxt [NL];

  logic [lshc_pkg::LOG_W-1:0] span_r, span_nxt;
  logic [lshc_pkg::LOG_W-1:0] diff_r, diff_nxt;

  logic [lshc_pkg::LOG_W-1:0] dv_rem_r  [lshc_pkg::DIV_STAGES];
  logic [lshc_pkg::LOG_W-1:0] dv_rem_nxt [lshc_pkg::DIV_STAGES];
  logic [lshc_pkg::LOG_W-1:0] dv_span_r [lshc_pkg::DIV_STAGES];
  logic [lshc_pkg::Q_W-1:0]   dv_quo_r  [lshc_pkg::DIV_STAGES+1];
  logic [lshc_pkg::Q_W-1:0]   dv_quo_nxt [lshc_pkg::DIV_STAGES+1];
  logic                       dv_sat_r  [lshc_pkg::DIV_STAGES+1];

  logic [lshc_pkg::T_W-1:0] t_r, t_nxt;
  logic [lshc_pkg::T_W-1:0] gw_r, gw_nxt;

  lshc_pkg::pix_t col_c;
  logic           push;
  logic           out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  lshc_pkg::pix_t out_res_r, out_res_nxt, skid_res_r, skid_res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r <= lshc_pkg::DISPLAY_MIN_RST;
      cfg_max_r <= lshc_pkg::DISPLAY_MAX_RST;
    end else if (cfg_we) begin
      case (lshc_pkg::cfg_idx_t'(cfg_index))
        lshc_pkg::CFG_DISPLAY_MIN: cfg_min_r <= cfg_data;
        lshc_pkg::CFG_DISPLAY_MAX: cfg_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // Bounds after flooring; the upper bound may need one extra bit.
  always_comb begin
    logic [lshc_pkg::VAL_W-1:0] gap;
    bnd_min_nxt = (cfg_min_r < lshc_pkg::MIN_FLOOR) ? lshc_pkg::MIN_FLOOR : cfg_min_r;
    gap         = {1'b0, bnd_min_nxt} + {1'b0, lshc_pkg::SPAN_GAP};
    bnd_max_nxt = ({1'b0, cfg_max_r} < gap) ? gap : {1'b0, cfg_max_r};
  end

  always_comb begin
    logic [lshc_pkg::VAL_W-1:0] gv;
    gv = {1'b0, raw_gain_r};
    if (gv < {1'b0, bnd_min_r}) begin
      gv = {1'b0, bnd_min_r};
    end else if (gv > bnd_max_r) begin
      gv = bnd_max_r;
    end
    val_nxt[lshc_pkg::LANE_G]   = gv;
    val_nxt[lshc_pkg::LANE_MIN] = {1'b0, bnd_min_r};
    val_nxt[lshc_pkg::LANE_MAX] = bnd_max_r;
  end

  // log2 lanes: normalise, table position, table read, interpolation, sum.
  always_comb begin
    logic [lshc_pkg::POS_W-1:0]   pos;
    logic [lshc_pkg::IDX_W:0]     idx_hi;
    logic [lshc_pkg::TAB_W-1:0]   hi;
    for (int l = 0; l < NL; l++) begin
      exp2_nxt[l] = '0;
      for (int b = 0; b < lshc_pkg::VAL_W; b++) begin
        if (val_r[l][b]) begin
          exp2_nxt[l] = lshc_pkg::EXP_W'(b);
        end
      end
      frac_nxt[l] = lshc_pkg::FRAC_BITS'({val_r[l], {lshc_pkg::FRAC_BITS{1'b0}}} >> exp2_nxt[l]);

      pos         = lshc_pkg::POS_W'(frac_r[l]) * lshc_pkg::POS_W'(lshc_pkg::LOG_TABLE_ENTRIES);
      idx_nxt[l]  = lshc_pkg::IDX_W'(pos >> lshc_pkg::FRAC_BITS);
      rem3_nxt[l] = pos[lshc_pkg::FRAC_BITS-1:0];

      idx_hi      = {1'b0, idx_r[l]} + 1'b1;
      lo4_nxt[l]  = lshc_pkg::LOG_TAB[{1'b0, idx_r[l]}];
      hi          = lshc_pkg::LOG_TAB[idx_hi];
      dlt_nxt[l]  = (hi < lo4_nxt[l]) ? '0 : hi - lo4_nxt[l];

      prod_nxt[l] = lshc_pkg::PROD_W'(dlt_r[l]) * lshc_pkg::PROD_W'(rem4_r[l]);

      log_nxt[l]  = lshc_pkg::LOG_W'({exp5_r[l], {lshc_pkg::Q_W{1'b0}}})
                  + lshc_pkg::LOG_W'(lo5_r[l])
                  + lshc_pkg::LOG_W'(prod_r[l] >> lshc_pkg::FRAC_BITS);
    end
  end

  always_comb begin
    logic [lshc_pkg::LOG_W-1:0] lg, lmn, lmx, sp;
    lg       = log_r[lshc_pkg::LANE_G];
    lmn      = log_r[lshc_pkg::LANE_MIN];
    lmx      = log_r[lshc_pkg::LANE_MAX];
    sp       = (lmx > lmn) ? lmx - lmn : '0;
    span_nxt = (sp < lshc_pkg::LOG_SPAN_FLOOR) ? lshc_pkg::LOG_SPAN_FLOOR : sp;
    diff_nxt = (lg > lmn) ? lg - lmn : '0;
  end

  // Restoring divider, one quotient bit per stage. The first stage settles saturation.
  always_comb begin
    logic [lshc_pkg::LOG_W:0] r2;
    dv_rem_nxt[0] = (diff_r >= span_r) ? '0 : diff_r;
    dv_quo_nxt[0] = '0;
    for (int j = 1; j <= lshc_pkg::DIV_STAGES; j++) begin
      r2 = {dv_rem_r[j-1], 1'b0};
      if (r2 >= {1'b0, dv_span_r[j-1]}) begin
        r2            = r2 - {1'b0, dv_span_r[j-1]};
        dv_quo_nxt[j] = {dv_quo_r[j-1][lshc_pkg::Q_W-2:0], 1'b1};
      end else begin
        dv_quo_nxt[j] = {dv_quo_r[j-1][lshc_pkg::Q_W-2:0], 1'b0};
      end
      if (j < lshc_pkg::DIV_STAGES) begin
        dv_rem_nxt[j] = r2[lshc_pkg::LOG_W-1:0];
      end
    end
  end

  always_comb begin
    logic [lshc_pkg::T_W:0] two_t, dev;
    t_nxt  = dv_sat_r[lshc_pkg::DIV_STAGES] ? lshc_pkg::T_ONE
                                            : {1'b0, dv_quo_r[lshc_pkg::DIV_STAGES]};
    two_t  = {t_nxt, 1'b0};
    dev    = (two_t >= {1'b0, lshc_pkg::T_ONE}) ? two_t - {1'b0, lshc_pkg::T_ONE}
                                                : {1'b0, lshc_pkg::T_ONE} - two_t;
    gw_nxt = lshc_pkg::T_W'({1'b0, lshc_pkg::T_ONE} - dev);
  end

  always_comb begin
    col_c.red        = lshc_pkg::COL_W'((lshc_pkg::PIX_W'(t_r) * lshc_pkg::RB_SCALE)
                                        >> lshc_pkg::Q_W);
    col_c.green      = lshc_pkg::COL_W'((lshc_pkg::PIX_W'(gw_r) * lshc_pkg::G_SCALE)
                                        >> lshc_pkg::Q_W);
    col_c.blue       = lshc_pkg::COL_W'((lshc_pkg::PIX_W'(lshc_pkg::T_ONE - t_r)
                                        * lshc_pkg::RB_SCALE) >> lshc_pkg::Q_W);
    col_c.row_done   = mark_r[lshc_pkg::ST_LAST].line_end;
    col_c.frame_done = mark_r[lshc_pkg::ST_LAST].frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[lshc_pkg::STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mark_r[0]  <= '{line_end: in_line_end, frame_end: in_frame_end};
      for (int k = 1; k < lshc_pkg::STAGES; k++) begin
        mark_r[k] <= mark_r[k-1];
      end
      bnd_min_r  <= bnd_min_nxt;
      bnd_max_r  <= bnd_max_nxt;
      raw_gain_r <= in_gain_value;
      for (int l = 0; l < NL; l++) begin
        val_r[l]  <= val_nxt[l];
        exp2_r[l] <= exp2_nxt[l];
        frac_r[l] <= frac_nxt[l];
        exp3_r[l] <= exp2_r[l];
        idx_r[l]  <= idx_nxt[l];
        rem3_r[l] <= rem3_nxt[l];
        exp4_r[l] <= exp3_r[l];
        lo4_r[l]  <= lo4_nxt[l];
        dlt_r[l]  <= dlt_nxt[l];
        rem4_r[l] <= rem3_r[l];
        exp5_r[l] <= exp4_r[l];
        lo5_r[l]  <= lo4_r[l];
        prod_r[l] <= prod_nxt[l];
        log_r[l]  <= log_nxt[l];
      end
      span_r <= span_nxt;
      diff_r <= diff_nxt;
      dv_span_r[0] <= span_r;
      dv_sat_r[0]  <= (diff_r >= span_r);
      for (int j = 1; j <= lshc_pkg::DIV_STAGES; j++) begin
        dv_sat_r[j] <= dv_sat_r[j-1];
        if (j < lshc_pkg::DIV_STAGES) begin
          dv_span_r[j] <= dv_span_r[j-1];
        end
      end
      for (int j = 0; j <= lshc_pkg::DIV_STAGES; j++) begin
        dv_quo_r[j] <= dv_quo_nxt[j];
        if (j < lshc_pkg::DIV_STAGES) begin
          dv_rem_r[j] <= dv_rem_nxt[j];
        end
      end
      t_r  <= t_nxt;
      gw_r <= gw_nxt;
    end
  end

  // Output register with a one-beat skid register behind it.
  assign push = en && vld_r[lshc_pkg::ST_LAST];

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (out_vld_r && out_ready) begin
      if (skid_vld_r) begin
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_res_nxt = col_c;
      end
    end else if (!out_vld_r) begin
      out_vld_nxt = push;
      out_res_nxt = col_c;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = col_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_red        = out_res_r.red;
  assign out_green      = out_res_r.green;
  assign out_blue       = out_res_r.blue;
  assign out_row_done   = out_res_r.row_done;
  assign out_frame_done = out_res_r.frame_done;

  `ASSERT_RST(a_skid_behind_out, clk, rst_n, skid_vld_r |-> out_vld_r, "skid full with output empty")
  `ASSERT_RST(a_stall_to_skid, clk, rst_n, (push && out_vld_r && !out_ready) |=> skid_vld_r, "stalled beat not held in skid")
  `ASSERT_RST(a_div_rem, clk, rst_n, (vld_r[lshc_pkg::ST_DIV0] && !dv_sat_r[0]) |-> (dv_rem_r[0] < dv_span_r[0]), "divider remainder not below span")
  `ASSERT_RST(a_t_range, clk, rst_n, vld_r[lshc_pkg::ST_LAST] |-> (t_r <= lshc_pkg::T_ONE), "scale position above one")
  `ASSERT_RST(a_green_peak, clk, rst_n, out_vld_r |-> (out_res_r.green <= lshc_pkg::G_PEAK), "green above its peak")

endmodule
